// ===== sv/bev_pkg.sv =====
// Shared constants, types and arithmetic helpers for the Euler angle basis block.
`default_nettype none
package bev_pkg;

	// Widths of the angle inputs and of the result fields.
	localparam int ANGLE_BITS    = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int OUT_W         = 16;
	localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;

	// Q2.30 constants.
	localparam logic [30:0] Q_ONE      = 31'h4000_0000;
	localparam logic [29:0] Q_HALF     = 30'h2000_0000;
	localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

	// Taylor series terms and the matching divisors with their reciprocals (floor of 2^32/k).
	localparam int SIN_TERMS = 5;
	localparam int COS_TERMS = 6;
	localparam logic [7:0]  SIN_DIV [SIN_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [31:0] SIN_RCP [SIN_TERMS] = '{32'd39045157, 32'd59652323,
		32'd102261126, 32'd214748364, 32'd715827882};
	localparam logic [7:0]  COS_DIV [COS_TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
	localparam logic [31:0] COS_RCP [COS_TERMS] = '{32'd32537631, 32'd47721858,
		32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

	// Pipeline depths.
	localparam int STEP_STAGES  = 3;
	localparam int CHAIN_DLY    = STEP_STAGES * SIN_TERMS;
	localparam int X2_DLY       = STEP_STAGES * (COS_TERMS - 1);
	localparam int SIN_PAD      = STEP_STAGES * (COS_TERMS - SIN_TERMS) - 1;
	localparam int LANE_STAGES  = 2 + STEP_STAGES * COS_TERMS + 1;
	localparam int META_DLY     = LANE_STAGES - 2;
	localparam int MERGE_STAGES = 3;
	localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;
	localparam int NUM_OUT      = 9;

	// Quadrant and mirror flag of one angle.
	typedef struct packed {
		logic [1:0] quad;
		logic       swap;
	} octant_t;

	// Signed Q30 product, magnitude rounded half away from zero.
	function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic        neg;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [63:0] m;
		neg = a[31] ^ b[31];
		ma  = a[31] ? 32'(-a) : 32'(a);
		mb  = b[31] ? 32'(-b) : 32'(b);
		m   = (64'(ma) * 64'(mb) + 64'(Q_HALF)) >> 30;
		return neg ? -$signed(32'(m)) : $signed(32'(m));
	endfunction

	// Q2.30 to the output format with rounding and saturation to one.
	function automatic logic signed [OUT_W-1:0] to_out(input logic signed [32:0] v);
		logic        neg;
		logic [32:0] mag;
		logic [32:0] m;
		neg = v[32];
		mag = neg ? 33'(-v) : 33'(v);
		m   = (mag + (33'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
		if (m > (33'd1 << OUT_FRAC_BITS)) begin
			m = 33'd1 << OUT_FRAC_BITS;
		end
		return neg ? -$signed(OUT_W'(m)) : $signed(OUT_W'(m));
	endfunction

endpackage
`default_nettype wire

// ===== sv/bev_horner_step.sv =====
// One Horner step of the Taylor series: t = ONE - floor(round(x2*t) / k), three stages.
`default_nettype none
module bev_horner_step (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [7:0]  k,
	input  wire logic [31:0] rcp,
	input  wire logic [29:0] x2,
	input  wire logic [30:0] t_in,
	output logic      [30:0] t_out
);

	logic [60:0] prod;
	logic [29:0] n_s1;
	logic [61:0] p_s2;
	logic [29:0] n_s2;
	logic [29:0] q0;
	logic [37:0] diff;
	logic [29:0] r;
	logic [29:0] qq;
	logic [30:0] t_s3;

	// Stage one: rounded product of x squared and the running term.
	assign prod = 61'(x2) * 61'(t_in);

	// Stage three: the reciprocal estimate is low by at most one, fix it up.
	always_comb begin
		q0   = p_s2[61:32];
		diff = 38'(n_s2) - 38'(q0) * 38'(k);
		r    = diff[29:0];
		qq   = q0 + 30'(r >= 30'(k));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= 30'((prod + 61'(bev_pkg::Q_HALF)) >> 30);
			p_s2 <= 62'(n_s1) * 62'(rcp);
			n_s2 <= n_s1;
			t_s3 <= bev_pkg::Q_ONE - 31'(qq);
		end
	end

	assign t_out = t_s3;

endmodule
`default_nettype wire

// ===== sv/bev_sincos.sv =====
// Sine and cosine lane for one binary angle, fully pipelined.
`default_nettype none
module bev_sincos (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic [bev_pkg::ANGLE_BITS-1:0] angle,
	output logic signed [31:0]                  sn,
	output logic signed [31:0]                  cs
);

	logic [31:0]       phase;
	logic [29:0]       u;
	logic              swap;
	logic [29:0]       um;
	logic [60:0]       xprod;
	logic [59:0]       x2prod;
	logic [29:0]       x_s1;
	logic [29:0]       x2_s2;
	logic [29:0]       x_s2;
	bev_pkg::octant_t  meta_s1;
	bev_pkg::octant_t  meta_q [bev_pkg::META_DLY];
	logic [29:0]       x2_q [bev_pkg::X2_DLY];
	logic [29:0]       x_q [bev_pkg::CHAIN_DLY];
	logic [30:0]       sin_t [bev_pkg::SIN_TERMS+1];
	logic [30:0]       cos_t [bev_pkg::COS_TERMS+1];
	logic [60:0]       sprod;
	logic [30:0]       s_q;
	logic [30:0]       s_dly_q [bev_pkg::SIN_PAD];
	logic [30:0]       s_f;
	logic [30:0]       c_f;
	bev_pkg::octant_t  meta_f;
	logic signed [31:0] sn_q;
	logic signed [31:0] cs_q;

	// Reduce the angle to a quarter turn and mirror the upper eighth.
	always_comb begin
		phase = {angle, {(32 - bev_pkg::ANGLE_BITS){1'b0}}};
		u     = phase[29:0];
		swap  = u > bev_pkg::Q_HALF;
		um    = swap ? 30'(bev_pkg::Q_ONE - 31'(u)) : u;
		xprod = 61'(um) * 61'(bev_pkg::HALF_PI_Q30);
	end

	assign x2prod = 60'(x_s1) * 60'(x_s1);

	// Front stages: radians, then the square.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1         <= 30'((xprod + 61'(bev_pkg::Q_HALF)) >> 30);
			meta_s1.quad <= phase[31:30];
			meta_s1.swap <= swap;
			x2_s2        <= 30'((x2prod + 60'(bev_pkg::Q_HALF)) >> 30);
			x_s2         <= x_s1;
		end
	end

	// Delay lines that keep x, x squared and the octant in step with the series.
	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0] <= meta_s1;
			for (int i = 1; i < bev_pkg::META_DLY; i++) begin
				meta_q[i] <= meta_q[i-1];
			end
			x2_q[0] <= x2_s2;
			for (int i = 1; i < bev_pkg::X2_DLY; i++) begin
				x2_q[i] <= x2_q[i-1];
			end
			x_q[0] <= x_s2;
			for (int i = 1; i < bev_pkg::CHAIN_DLY; i++) begin
				x_q[i] <= x_q[i-1];
			end
		end
	end

	// Sine and cosine series run side by side, one Horner step per three stages.
	assign sin_t[0] = bev_pkg::Q_ONE;
	assign cos_t[0] = bev_pkg::Q_ONE;

	for (genvar j = 0; j < bev_pkg::SIN_TERMS; j++) begin : g_sin
		bev_horner_step u_step (
			.clk   (clk),
			.en    (en),
			.k     (bev_pkg::SIN_DIV[j]),
			.rcp   (bev_pkg::SIN_RCP[j]),
			.x2    ((j == 0) ? x2_s2 : x2_q[(j == 0) ? 0 : bev_pkg::STEP_STAGES*j - 1]),
			.t_in  (sin_t[j]),
			.t_out (sin_t[j+1])
		);
	end

	for (genvar j = 0; j < bev_pkg::COS_TERMS; j++) begin : g_cos
		bev_horner_step u_step (
			.clk   (clk),
			.en    (en),
			.k     (bev_pkg::COS_DIV[j]),
			.rcp   (bev_pkg::COS_RCP[j]),
			.x2    ((j == 0) ? x2_s2 : x2_q[(j == 0) ? 0 : bev_pkg::STEP_STAGES*j - 1]),
			.t_in  (cos_t[j]),
			.t_out (cos_t[j+1])
		);
	end

	// Sine is x times the series, then padded to line up with the cosine.
	assign sprod = 61'(x_q[bev_pkg::CHAIN_DLY-1]) * 61'(sin_t[bev_pkg::SIN_TERMS]);

	always_ff @(posedge clk) begin
		if (en) begin
			s_q        <= 31'((sprod + 61'(bev_pkg::Q_HALF)) >> 30);
			s_dly_q[0] <= s_q;
			for (int i = 1; i < bev_pkg::SIN_PAD; i++) begin
				s_dly_q[i] <= s_dly_q[i-1];
			end
		end
	end

	// Undo the mirror and apply the quadrant signs.
	always_comb begin
		meta_f = meta_q[bev_pkg::META_DLY-1];
		s_f    = meta_f.swap ? cos_t[bev_pkg::COS_TERMS] : s_dly_q[bev_pkg::SIN_PAD-1];
		c_f    = meta_f.swap ? s_dly_q[bev_pkg::SIN_PAD-1] : cos_t[bev_pkg::COS_TERMS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (meta_f.quad)
				2'd0: begin
					sn_q <= $signed(32'(s_f));
					cs_q <= $signed(32'(c_f));
				end
				2'd1: begin
					sn_q <= $signed(32'(c_f));
					cs_q <= -$signed(32'(s_f));
				end
				2'd2: begin
					sn_q <= -$signed(32'(s_f));
					cs_q <= -$signed(32'(c_f));
				end
				default: begin
					sn_q <= -$signed(32'(c_f));
					cs_q <= $signed(32'(s_f));
				end
			endcase
		end
	end

	assign sn = sn_q;
	assign cs = cs_q;

endmodule
`default_nettype wire

// ===== sv/bev_merge.sv =====
// Merges the three lanes into the nine basis entries: products, sums and output rounding.
`default_nettype none
module bev_merge (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic                    transpose,
	input  wire logic signed [31:0]      sp,
	input  wire logic signed [31:0]      cp,
	input  wire logic signed [31:0]      sy,
	input  wire logic signed [31:0]      cy,
	input  wire logic signed [31:0]      sr,
	input  wire logic signed [31:0]      cr,
	output logic signed [bev_pkg::OUT_W-1:0] res [bev_pkg::NUM_OUT]
);

	logic signed [31:0] srsp_s1, crsp_s1, cpcy_s1, cpsy_s1, crsy_s1, crcy_s1;
	logic signed [31:0] srsy_s1, srcy_s1, srcp_s1, crcp_s1, sp_s1, cy_s1, sy_s1;
	logic signed [31:0] srspcy_s2, srspsy_s2, crspcy_s2, crspsy_s2;
	logic signed [31:0] cpcy_s2, cpsy_s2, crsy_s2, crcy_s2, srsy_s2, srcy_s2;
	logic signed [31:0] srcp_s2, crcp_s2, sp_s2;
	logic signed [32:0] m [bev_pkg::NUM_OUT];
	logic signed [bev_pkg::OUT_W-1:0] res_s3 [bev_pkg::NUM_OUT];

	// Stage one: the pairwise products that the sums need.
	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s1 <= bev_pkg::qmul(sr, sp);
			crsp_s1 <= bev_pkg::qmul(cr, sp);
			cpcy_s1 <= bev_pkg::qmul(cp, cy);
			cpsy_s1 <= bev_pkg::qmul(cp, sy);
			crsy_s1 <= bev_pkg::qmul(cr, sy);
			crcy_s1 <= bev_pkg::qmul(cr, cy);
			srsy_s1 <= bev_pkg::qmul(sr, sy);
			srcy_s1 <= bev_pkg::qmul(sr, cy);
			srcp_s1 <= bev_pkg::qmul(sr, cp);
			crcp_s1 <= bev_pkg::qmul(cr, cp);
			sp_s1   <= sp;
			cy_s1   <= cy;
			sy_s1   <= sy;
		end
	end

	// Stage two: triple products, formed left to right.
	always_ff @(posedge clk) begin
		if (en) begin
			srspcy_s2 <= bev_pkg::qmul(srsp_s1, cy_s1);
			srspsy_s2 <= bev_pkg::qmul(srsp_s1, sy_s1);
			crspcy_s2 <= bev_pkg::qmul(crsp_s1, cy_s1);
			crspsy_s2 <= bev_pkg::qmul(crsp_s1, sy_s1);
			cpcy_s2   <= cpcy_s1;
			cpsy_s2   <= cpsy_s1;
			crsy_s2   <= crsy_s1;
			crcy_s2   <= crcy_s1;
			srsy_s2   <= srsy_s1;
			srcy_s2   <= srcy_s1;
			srcp_s2   <= srcp_s1;
			crcp_s2   <= crcp_s1;
			sp_s2     <= sp_s1;
		end
	end

	// Stage three: exact sums in either orientation.
	always_comb begin
		m[0] = 33'(cpcy_s2);
		m[8] = 33'(crcp_s2);
		if (transpose) begin
			m[1] = 33'(srspcy_s2) - 33'(crsy_s2);
			m[2] = 33'(crspcy_s2) + 33'(srsy_s2);
			m[3] = 33'(cpsy_s2);
			m[4] = 33'(srspsy_s2) + 33'(crcy_s2);
			m[5] = 33'(crspsy_s2) - 33'(srcy_s2);
			m[6] = -33'(sp_s2);
			m[7] = 33'(srcp_s2);
		end else begin
			m[1] = 33'(cpsy_s2);
			m[2] = -33'(sp_s2);
			m[3] = 33'(crsy_s2) - 33'(srspcy_s2);
			m[4] = -33'(srspsy_s2) - 33'(crcy_s2);
			m[5] = -33'(srcp_s2);
			m[6] = 33'(crspcy_s2) + 33'(srsy_s2);
			m[7] = 33'(crspsy_s2) - 33'(srcy_s2);
		end
	end

	// Output register: rounded and saturated entries.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < bev_pkg::NUM_OUT; i++) begin
				res_s3[i] <= bev_pkg::to_out(m[i]);
			end
		end
	end

	assign res = res_s3;

endmodule
`default_nettype wire

// ===== sv/euler_angles_to_basis_vectors.sv =====
// Top level: Euler angles to rotation basis, three sine/cosine lanes and a merge stage.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_stall    pitch_angle, yaw_angle, roll_angle
//  output    out        out_valid / out_stall  row0_x .. row2_z
//  config    in         cfg_wr_en              cfg_wr_data (transpose mode)
//
// One item per cycle while the output is not stalled, through 24 register stages. The lanes
// take 21 stages (two front stages, six Horner steps of three stages each, one sign stage),
// the merge 3. The whole pipeline holds while a result waits at a stalled output.
// Reset clears the valid bits and the transpose mode; data registers are not reset.
`default_nettype none
module euler_angles_to_basis_vectors (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic                            cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [bev_pkg::ANGLE_BITS-1:0]  pitch_angle,
	input  wire logic [bev_pkg::ANGLE_BITS-1:0]  yaw_angle,
	input  wire logic [bev_pkg::ANGLE_BITS-1:0]  roll_angle,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [bev_pkg::OUT_W-1:0]     row0_x,
	output logic signed [bev_pkg::OUT_W-1:0]     row0_y,
	output logic signed [bev_pkg::OUT_W-1:0]     row0_z,
	output logic signed [bev_pkg::OUT_W-1:0]     row1_x,
	output logic signed [bev_pkg::OUT_W-1:0]     row1_y,
	output logic signed [bev_pkg::OUT_W-1:0]     row1_z,
	output logic signed [bev_pkg::OUT_W-1:0]     row2_x,
	output logic signed [bev_pkg::OUT_W-1:0]     row2_y,
	output logic signed [bev_pkg::OUT_W-1:0]     row2_z
);

	logic                            transpose_q;
	logic                            en;
	logic [bev_pkg::PIPE_STAGES-1:0] vld_q;
	logic signed [31:0]              sp, cp, sy, cy, sr, cr;
	logic signed [bev_pkg::OUT_W-1:0] res [bev_pkg::NUM_OUT];

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
		end else if (cfg_wr_en) begin
			transpose_q <= cfg_wr_data;
		end
	end

	// The pipeline moves unless a finished result is held at the output.
	assign en       = !(vld_q[bev_pkg::PIPE_STAGES-1] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[bev_pkg::PIPE_STAGES-2:0], in_valid};
		end
	end

	// One lane per angle.
	bev_sincos u_pitch (.clk(clk), .en(en), .angle(pitch_angle), .sn(sp), .cs(cp));
	bev_sincos u_yaw   (.clk(clk), .en(en), .angle(yaw_angle),   .sn(sy), .cs(cy));
	bev_sincos u_roll  (.clk(clk), .en(en), .angle(roll_angle),  .sn(sr), .cs(cr));

	bev_merge u_merge (
		.clk       (clk),
		.en        (en),
		.transpose (transpose_q),
		.sp        (sp),
		.cp        (cp),
		.sy        (sy),
		.cy        (cy),
		.sr        (sr),
		.cr        (cr),
		.res       (res)
	);

	assign out_valid = vld_q[bev_pkg::PIPE_STAGES-1];
	assign row0_x    = res[0];
	assign row0_y    = res[1];
	assign row0_z    = res[2];
	assign row1_x    = res[3];
	assign row1_y    = res[4];
	assign row1_z    = res[5];
	assign row2_x    = res[6];
	assign row2_y    = res[7];
	assign row2_z    = res[8];

endmodule
`default_nettype wire

// ===== sv/bev_checker.sv =====
// Port-level checker for the Euler angle basis block, bound to the top level.
`default_nettype none
module bev_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [bev_pkg::OUT_W-1:0] row0_x,
	input wire logic signed [bev_pkg::OUT_W-1:0] row1_y,
	input wire logic signed [bev_pkg::OUT_W-1:0] row2_z
);

	// A held result freezes the pipeline, so no new transfer may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted while output is held");

	// With no result waiting, the block takes input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

	// The diagonal basis entries never leave the unit range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row0_x <= 16'sd16384 && row0_x >= -16'sd16384 &&
			row1_y <= 16'sd16384 && row1_y >= -16'sd16384 &&
			row2_z <= 16'sd16384 && row2_z >= -16'sd16384)
		else $error("basis entry out of range");

	// A stalled result stays and holds its row0_x and row2_z values.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row0_x) && $stable(row2_z))
		else $error("stalled result changed");

endmodule

bind euler_angles_to_basis_vectors bev_checker u_bev_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.row0_x    (row0_x),
	.row1_y    (row1_y),
	.row2_z    (row2_z)
);
`default_nettype wire

// ===== sim/basis_checker.sv =====
// Checker for the Euler angle basis block: computes expected basis rows and compares results.
`timescale 1ns / 100ps
`default_nettype none
module basis_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [15:0]        pitch_angle,
	input  wire logic [15:0]        yaw_angle,
	input  wire logic [15:0]        roll_angle,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [15:0] row0_x,
	input  wire logic signed [15:0] row0_y,
	input  wire logic signed [15:0] row0_z,
	input  wire logic signed [15:0] row1_x,
	input  wire logic signed [15:0] row1_y,
	input  wire logic signed [15:0] row1_z,
	input  wire logic signed [15:0] row2_x,
	input  wire logic signed [15:0] row2_y,
	input  wire logic signed [15:0] row2_z,
	output int                      fail_count,
	output int                      pending_rows
);

	typedef struct {
		logic signed [15:0] v [9];
	} basis_t;

	localparam longint ONE_Q30  = 64'd1 << 30;
	localparam longint HALF_Q30 = 64'd1 << 29;

	logic   tmode;
	basis_t expected_bases[$];
	string  row_names [9] = '{"row0_x", "row0_y", "row0_z", "row1_x", "row1_y", "row1_z",
		"row2_x", "row2_y", "row2_z"};

	// Rounded Q30 product with half away from zero on the magnitude.
	function automatic longint mul_q30(input longint a, input longint b);
		bit     neg;
		longint ma;
		longint mb;
		longint m;
		neg = (a < 0) != (b < 0);
		ma  = a < 0 ? -a : a;
		mb  = b < 0 ? -b : b;
		m   = (ma * mb + HALF_Q30) >>> 30;
		return neg ? -m : m;
	endfunction

	// Sine and cosine of one binary angle by mirrored octant and Taylor series.
	function automatic void angle_sincos(input logic [15:0] ang, output longint sn,
		output longint cs);
		longint sdv [5];
		longint cdv [6];
		logic [31:0] ph;
		logic [1:0]  quad;
		longint u;
		longint x;
		longint x2;
		longint t;
		longint s;
		longint c;
		longint tmp;
		bit mirror;
		sdv  = '{110, 72, 42, 20, 6};
		cdv  = '{132, 90, 56, 30, 12, 2};
		ph   = {ang, 16'h0};
		quad = ph[31:30];
		u    = ph[29:0];
		mirror = u > HALF_Q30;
		if (mirror) begin
			u = ONE_Q30 - u;
		end
		x  = (u * 64'h6487ED51 + HALF_Q30) >> 30;
		x2 = (x * x + HALF_Q30) >> 30;
		t  = ONE_Q30;
		for (int i = 0; i < 5; i++) begin
			t = ONE_Q30 - ((x2 * t + HALF_Q30) >> 30) / sdv[i];
		end
		s = (x * t + HALF_Q30) >> 30;
		t = ONE_Q30;
		for (int i = 0; i < 6; i++) begin
			t = ONE_Q30 - ((x2 * t + HALF_Q30) >> 30) / cdv[i];
		end
		c = t;
		if (mirror) begin
			tmp = s;
			s   = c;
			c   = tmp;
		end
		case (quad)
			2'd0: begin sn = s;  cs = c;  end
			2'd1: begin sn = c;  cs = -s; end
			2'd2: begin sn = -s; cs = -c; end
			default: begin sn = -c; cs = s; end
		endcase
	endfunction

	// Q30 to the signed output format with rounding and saturation at one.
	function automatic logic signed [15:0] q30_to_field(input longint v);
		bit     neg;
		longint m;
		neg = v < 0;
		m   = neg ? -v : v;
		m   = (m + (64'd1 << 15)) >> 16;
		if (m > 16384) begin
			m = 16384;
		end
		return neg ? 16'(-m) : 16'(m);
	endfunction

	// Nine basis entries for one angle triple under the given mode.
	function automatic basis_t predict_basis(input logic [15:0] p, input logic [15:0] y,
		input logic [15:0] r, input logic tr);
		longint sp, cp, sy, cy, sr, cr, srsp, crsp;
		longint m [9];
		basis_t b;
		angle_sincos(p, sp, cp);
		angle_sincos(y, sy, cy);
		angle_sincos(r, sr, cr);
		srsp = mul_q30(sr, sp);
		crsp = mul_q30(cr, sp);
		if (!tr) begin
			m[0] = mul_q30(cp, cy);
			m[1] = mul_q30(cp, sy);
			m[2] = -sp;
			m[3] = -mul_q30(srsp, cy) + mul_q30(cr, sy);
			m[4] = -mul_q30(srsp, sy) - mul_q30(cr, cy);
			m[5] = -mul_q30(sr, cp);
			m[6] = mul_q30(crsp, cy) + mul_q30(sr, sy);
			m[7] = mul_q30(crsp, sy) - mul_q30(sr, cy);
		end else begin
			m[0] = mul_q30(cp, cy);
			m[1] = mul_q30(srsp, cy) - mul_q30(cr, sy);
			m[2] = mul_q30(crsp, cy) + mul_q30(sr, sy);
			m[3] = mul_q30(cp, sy);
			m[4] = mul_q30(srsp, sy) + mul_q30(cr, cy);
			m[5] = mul_q30(crsp, sy) - mul_q30(sr, cy);
			m[6] = -sp;
			m[7] = mul_q30(sr, cp);
		end
		m[8] = mul_q30(cr, cp);
		for (int i = 0; i < 9; i++) begin
			b.v[i] = q30_to_field(m[i]);
		end
		return b;
	endfunction

	// Track the mode, queue a prediction per input transfer, compare each output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		basis_t exp_b;
		logic signed [15:0] got [9];
		int errs;
		if (!arst_n) begin
			tmode        <= 1'b0;
			fail_count   <= 0;
			pending_rows <= 0;
		end else begin
			errs = 0;
			if (cfg_wr_en) begin
				tmode <= cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				expected_bases.push_back(predict_basis(pitch_angle, yaw_angle, roll_angle,
					tmode));
			end
			if (out_valid && !out_stall) begin
				got = '{row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x, row2_y, row2_z};
				if (expected_bases.size() == 0) begin
					$error("Output transfer with no result expected");
					errs++;
				end else begin
					exp_b = expected_bases.pop_front();
					for (int i = 0; i < 9; i++) begin
						if (got[i] !== exp_b.v[i]) begin
							$error("%s mismatch: expected %0d, actual %0d", row_names[i],
								exp_b.v[i], got[i]);
							errs++;
						end
					end
				end
			end
			fail_count   <= fail_count + errs;
			pending_rows <= expected_bases.size();
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the Euler angle basis block.
`timescale 1ns / 100ps
`default_nettype none
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] pitch_angle = '0;
	logic [15:0] yaw_angle = '0;
	logic [15:0] roll_angle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] row0_x, row0_y, row0_z, row1_x, row1_y, row1_z, row2_x, row2_y, row2_z;
	int fail_count;
	int pending_rows;
	int angle_count = 0;
	bit stall_runs = 1'b1;
	int gap_max = 10;

	euler_angles_to_basis_vectors i_dut (.*);
	basis_checker i_chk (.*);

	// Clock with a period of 8 ns.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stall stretches between transfers.
	always @(posedge clk) begin
		int n;
		if (out_valid && !out_stall) begin
			n = stall_runs ? $urandom_range(0, 10) : 0;
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// After a random idle gap, send one angle triple and wait for its transfer.
	task automatic send_angles(input logic [15:0] p, input logic [15:0] y, input logic [15:0] r);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		pitch_angle <= p;
		yaw_angle   <= y;
		roll_angle  <= r;
		do @(posedge clk); while (in_stall);
		angle_count++;
	endtask

	// Drain every result, then write the mode while the pipeline is empty.
	task automatic set_mode(input logic m);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_rows != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// A random angle, biased toward octant boundaries now and then.
	function automatic logic [15:0] pick_angle();
		if ($urandom_range(0, 3) == 0) begin
			return 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 4) - 2);
		end
		return 16'($urandom);
	endfunction

	task automatic random_angles(input int n);
		for (int i = 0; i < n; i++) begin
			send_angles(pick_angle(), pick_angle(), pick_angle());
		end
	endtask

	task automatic directed_angles();
		logic [15:0] corners [8];
		corners = '{16'h0000, 16'h2000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h1FFF,
			16'h2001};
		for (int i = 0; i < 8; i++) begin
			send_angles(corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]);
		end
		send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_angles(16'h5555, 16'hAAAA, 16'h0001);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_angles();
		random_angles(200);
		set_mode(1'b1);
		directed_angles();
		// Back-to-back stretch without idling on either side.
		gap_max    = 0;
		stall_runs = 1'b0;
		random_angles(150);
		gap_max    = 10;
		stall_runs = 1'b1;
		random_angles(150);
		set_mode(1'b0);
		random_angles(150);
		set_mode(1'b1);
		random_angles(150);
		in_valid <= 1'b0;
		while (pending_rows != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Covered %0d angle triples over both basis modes and octant boundaries.",
			angle_count);
		if (fail_count == 0) begin
			$display("[euler_angles_to_basis_vectors] OK");
		end else begin
			$display("[euler_angles_to_basis_vectors] ERROR");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("[euler_angles_to_basis_vectors] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/bev_pkg.sv
sv/bev_horner_step.sv
sv/bev_sincos.sv
sv/bev_merge.sv
sv/euler_angles_to_basis_vectors.sv
sv/bev_checker.sv
sim/basis_checker.sv
sim/tb.sv
